FILE: sv/lebs_pkg.sv
// Package of the LED event blink sequencer: types, codes, defaults and helpers.
package lebs_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned CFG_DATA_W     = 24;

  localparam logic [23:0] HB_TIMEOUT_RST  = 24'd15000;
  localparam logic [15:0] ACK_PULSE_RST   = 16'd100;
  localparam logic [7:0]  ACK_FLASHES_RST = 8'd3;
  localparam logic [15:0] HB_PULSE_RST    = 16'd500;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ACK    = 3'd1,
    OP_HB     = 3'd2,
    OP_START  = 3'd3,
    OP_STOP   = 3'd4,
    OP_LOCK   = 3'd5,
    OP_UNLOCK = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_BLINK_ON  = 3'd1,
    PH_BLINK_OFF = 3'd2,
    PH_ACK_ON    = 3'd3,
    PH_ACK_OFF   = 3'd4,
    PH_HB_ON     = 3'd5
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HB_TIMEOUT  = 8'd0,
    CFG_ACK_PULSE   = 8'd1,
    CFG_ACK_FLASHES = 8'd2,
    CFG_HB_PULSE    = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] hb_timeout;
    logic [15:0] ack_pulse_time;
    logic [7:0]  ack_flashes;
    logic [15:0] hb_pulse_time;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  blink_count;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic        notify_on_finish;
  } item_t;

  typedef struct packed {
    logic led;
    logic finished;
    logic busy_res;
  } res_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] ticks_left;
    logic [7:0]  cycles_left;
    logic [7:0]  count;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic        finish_wanted;
    logic        stop_req;
    logic        locked;
    logic        pending_ack;
    logic        pending_blink;
  } st_t;

  function automatic logic [15:0] dur(input logic [15:0] x);
    return (x == 16'd0) ? 16'd1 : x;
  endfunction

endpackage

FILE: sv/lebs_if.sv
// Handshake interfaces of the LED event blink sequencer: items, results, config writes.
interface lebs_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  blink_count;
  logic [15:0] on_time;
  logic [15:0] off_time;
  logic        notify_on_finish;
  modport source (output valid, op, blink_count, on_time, off_time, notify_on_finish,
                  input ready);
  modport sink (input valid, op, blink_count, on_time, off_time, notify_on_finish,
                output ready);
endinterface

interface lebs_result_if;
  logic valid;
  logic ready;
  logic led;
  logic finished;
  logic busy_res;
  modport source (output valid, led, finished, busy_res, input ready);
  modport sink (input valid, led, finished, busy_res, output ready);
endinterface

interface lebs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/lebs_step.sv
// Next-state and result logic of the LED event blink sequencer for one item.
module lebs_step
  import lebs_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  cfg_t                  cfg_i,
  input  item_t                 item_i,
  input  st_t                   st_i,
  input  logic [TIME_WIDTH-1:0] time_now_i,
  input  logic [TIME_WIDTH-1:0] last_hb_i,
  input  logic [TIME_WIDTH-1:0] next_disp_i,
  output st_t                   st_o,
  output logic [TIME_WIDTH-1:0] time_now_o,
  output logic [TIME_WIDTH-1:0] last_hb_o,
  output logic [TIME_WIDTH-1:0] next_disp_o,
  output res_t                  res_o
);

  localparam int unsigned CW = (TIME_WIDTH > 24) ? TIME_WIDTH : 24;

  st_t                   s;
  logic [TIME_WIDTH-1:0] tn;
  logic [TIME_WIDTH-1:0] lhb;
  logic [TIME_WIDTH-1:0] ndt;
  logic                  fin;
  logic [CW-1:0]         timeout_w;
  logic [CW-1:0]         age_w;
  logic [CW-1:0]         next_w;

  always_comb begin
    s   = st_i;
    tn  = time_now_i;
    lhb = last_hb_i;
    ndt = next_disp_i;
    fin = 1'b0;

    case (item_i.op)
      OP_TICK: begin
        tn = time_now_i + 1'b1;
        if (s.phase != PH_IDLE) begin
          if (s.ticks_left > 16'd1) begin
            s.ticks_left = s.ticks_left - 16'd1;
          end else begin
            case (s.phase)
              PH_BLINK_ON: begin
                if (s.stop_req) begin
                  fin             = s.finish_wanted && !s.stop_req;
                  s.finish_wanted = 1'b0;
                  s.stop_req      = 1'b0;
                  s.cycles_left   = 8'd0;
                  s.phase         = PH_IDLE;
                  s.ticks_left    = 16'd0;
                end else begin
                  s.phase      = PH_BLINK_OFF;
                  s.ticks_left = dur(s.off_time);
                end
              end
              PH_BLINK_OFF: begin
                s.cycles_left = s.cycles_left - 8'd1;
                if (s.stop_req || s.cycles_left == 8'd0) begin
                  fin             = s.finish_wanted && !s.stop_req;
                  s.finish_wanted = 1'b0;
                  s.stop_req      = 1'b0;
                  s.cycles_left   = 8'd0;
                  s.phase         = PH_IDLE;
                  s.ticks_left    = 16'd0;
                end else begin
                  s.phase      = PH_BLINK_ON;
                  s.ticks_left = dur(s.on_time);
                end
              end
              PH_ACK_ON: begin
                s.phase      = PH_ACK_OFF;
                s.ticks_left = dur(cfg_i.ack_pulse_time);
              end
              PH_ACK_OFF: begin
                s.cycles_left = s.cycles_left - 8'd1;
                if (s.cycles_left == 8'd0) begin
                  s.phase      = PH_IDLE;
                  s.ticks_left = 16'd0;
                end else begin
                  s.phase      = PH_ACK_ON;
                  s.ticks_left = dur(cfg_i.ack_pulse_time);
                end
              end
              default: begin
                s.phase      = PH_IDLE;
                s.ticks_left = 16'd0;
              end
            endcase
          end
        end
      end
      OP_ACK: begin
        if (!s.locked) s.pending_ack = 1'b1;
      end
      OP_HB: begin
        if (!s.locked) lhb = time_now_i;
      end
      OP_START: begin
        s.stop_req      = 1'b0;
        s.count         = item_i.blink_count;
        s.on_time       = item_i.on_time;
        s.off_time      = item_i.off_time;
        s.finish_wanted = item_i.notify_on_finish;
        s.pending_blink = 1'b1;
      end
      OP_STOP:   s.stop_req = 1'b1;
      OP_LOCK:   s.locked   = 1'b1;
      OP_UNLOCK: s.locked   = 1'b0;
      default: ;
    endcase

    timeout_w = CW'(cfg_i.hb_timeout);
    age_w     = CW'(TIME_WIDTH'(tn - lhb));
    next_w    = CW'(tn) + timeout_w;

    if (s.phase == PH_IDLE) begin
      if (s.pending_blink) begin
        s.pending_blink = 1'b0;
        s.pending_ack   = 1'b0;
        s.cycles_left   = s.count;
        if (s.stop_req || s.cycles_left == 8'd0) begin
          fin             = s.finish_wanted && !s.stop_req;
          s.finish_wanted = 1'b0;
          s.stop_req      = 1'b0;
          s.cycles_left   = 8'd0;
          s.phase         = PH_IDLE;
          s.ticks_left    = 16'd0;
        end else begin
          s.phase      = PH_BLINK_ON;
          s.ticks_left = dur(s.on_time);
        end
      end else if (s.pending_ack) begin
        s.pending_ack = 1'b0;
        if (!s.locked) begin
          ndt           = next_w[TIME_WIDTH-1:0];
          s.cycles_left = cfg_i.ack_flashes;
          if (cfg_i.ack_flashes != 8'd0) begin
            s.phase      = PH_ACK_ON;
            s.ticks_left = dur(cfg_i.ack_pulse_time);
          end
        end
      end else if (!s.locked && tn >= ndt) begin
        if (age_w < timeout_w) begin
          s.phase      = PH_HB_ON;
          s.ticks_left = dur(cfg_i.hb_pulse_time);
        end
        ndt = next_w[TIME_WIDTH-1:0];
      end
    end

    st_o        = s;
    time_now_o  = tn;
    last_hb_o   = lhb;
    next_disp_o = ndt;

    res_o.led      = (s.phase == PH_BLINK_ON) || (s.phase == PH_ACK_ON) ||
                     (s.phase == PH_HB_ON);
    res_o.finished = fin;
    res_o.busy_res = (s.phase != PH_IDLE);
  end

endmodule

FILE: sv/led_event_blink_sequencer.sv
// Top level of the LED event blink sequencer: item register, state, config and result register.
//
// Items arrive on in_if (valid/ready): a tick (1 ms) or a command with its operands.
// Each accepted item yields exactly one result on out_if: the LED level, a one-item
// finished pulse and the busy flag as they stand after that item.
// Configuration registers are written on cfg_if (valid/ready, index, data), which is
// always ready; write them only while no item is in flight.
// Path: an accepted item is first held in the item register, then passed through the step
// logic into the result register, which drives out_if.
// Throughput: one item per cycle while out_if is not stalled; the state update of one item is a single pass
// through the step logic between the item register and the result register.
// When the receiver stalls, the result register holds and the item register
// fills; in_if.ready then drops until the result is taken.
// Reset clears the pattern state to idle with an acknowledge pending, zeroes the
// time counters and loads the default configuration.
module led_event_blink_sequencer
  import lebs_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lebs_item_if.sink     in_if,
  lebs_result_if.source out_if,
  lebs_cfg_if.sink      cfg_if
);

  cfg_t                  cfg_q;
  item_t                 item_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  res_t                  res_q;
  st_t                   st_q;
  st_t                   st_d;
  logic [TIME_WIDTH-1:0] time_now_q, time_now_d;
  logic [TIME_WIDTH-1:0] last_hb_q, last_hb_d;
  logic [TIME_WIDTH-1:0] next_disp_q, next_disp_d;
  res_t                  res_d;
  logic                  adv;
  logic                  in_take;

  assign adv     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_take = in_if.valid && in_if.ready;

  assign in_if.ready  = !in_valid_q || adv;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid    = out_valid_q;
  assign out_if.led      = res_q.led;
  assign out_if.finished = res_q.finished;
  assign out_if.busy_res = res_q.busy_res;

  lebs_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .cfg_i      (cfg_q),
    .item_i     (item_q),
    .st_i       (st_q),
    .time_now_i (time_now_q),
    .last_hb_i  (last_hb_q),
    .next_disp_i(next_disp_q),
    .st_o       (st_d),
    .time_now_o (time_now_d),
    .last_hb_o  (last_hb_d),
    .next_disp_o(next_disp_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hb_timeout     <= HB_TIMEOUT_RST;
      cfg_q.ack_pulse_time <= ACK_PULSE_RST;
      cfg_q.ack_flashes    <= ACK_FLASHES_RST;
      cfg_q.hb_pulse_time  <= HB_PULSE_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_HB_TIMEOUT:  cfg_q.hb_timeout     <= cfg_if.data;
        CFG_ACK_PULSE:   cfg_q.ack_pulse_time <= cfg_if.data[15:0];
        CFG_ACK_FLASHES: cfg_q.ack_flashes    <= cfg_if.data[7:0];
        CFG_HB_PULSE:    cfg_q.hb_pulse_time  <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op               <= in_if.op;
      item_q.blink_count      <= in_if.blink_count;
      item_q.on_time          <= in_if.on_time;
      item_q.off_time         <= in_if.off_time;
      item_q.notify_on_finish <= in_if.notify_on_finish;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase         <= PH_IDLE;
      st_q.ticks_left    <= '0;
      st_q.cycles_left   <= '0;
      st_q.count         <= '0;
      st_q.on_time       <= '0;
      st_q.off_time      <= '0;
      st_q.finish_wanted <= 1'b0;
      st_q.stop_req      <= 1'b0;
      st_q.locked        <= 1'b0;
      st_q.pending_ack   <= 1'b1;
      st_q.pending_blink <= 1'b0;
      time_now_q         <= '0;
      last_hb_q          <= '0;
      next_disp_q        <= '0;
    end else if (adv) begin
      st_q        <= st_d;
      time_now_q  <= time_now_d;
      last_hb_q   <= last_hb_d;
      next_disp_q <= next_disp_d;
    end
  end

endmodule
